@@ rtl/nss_pkg.sv @@
// Shared types and constants for the name string sanitizer.
// No dependencies; the top level, front end, queue and back end import this package.
package nss_pkg;

  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned MAX_BYTES    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPAND_ILLEGAL = 1'd1;

  localparam logic [15:0] CAPACITY_RESET = 16'd64;

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] EXPAND_LEAD     = 8'hC4;
  localparam logic [7:0] CONT_MARK       = 8'h80;
  localparam logic [7:0] CONT_MASK       = 8'h3F;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One classified input: cnt output bytes, byte 0 first.
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } cmd_t;

endpackage

@@ rtl/nss_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is set per instance from types in nss_pkg.
interface nss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/name_string_sanitizer.sv @@
// Top level of the name string sanitizer: front end, command queue, back end.
// Depends on nss_pkg, nss_stream_if, nss_front, nss_queue and nss_back.
//
//   channel  | dir | payload                     | transaction
//   ---------+-----+-----------------------------+---------------------------
//   in_i     | in  | in_byte[7:0]                | valid && ready
//   out_o    | out | out_byte[7:0], last_of_run  | valid && ready
//   cfg      | in  | cfg_idx_i, cfg_data_i[15:0] | cfg_we_i (0 capacity, 1 expand)
//
// An input byte is classified in its accept cycle; its 0 to 3 output bytes pass
// through the command queue and the output register, leaving one per cycle while
// out_o.ready is high; the single output register port sets this rate.
// in_i.ready drops only while the command queue is full.
// Reset clears all string state and sets capacity 64, expansion off.
module name_string_sanitizer #(
  parameter int unsigned QueueDepth = nss_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nss_stream_if.sink                     in_i,
  nss_stream_if.source                   out_o
);
  import nss_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t cmd, head;

  nss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  nss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  nss_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ rtl/nss_front.sv @@
// Front end: accepts input bytes, classifies them, tracks string state.
// Depends on nss_pkg and nss_stream_if; pushes commands into nss_queue.
module nss_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nss_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  nss_stream_if.sink                       in_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output nss_pkg::cmd_t                    cmd_o
);
  import nss_pkg::*;

  logic [15:0] cap_q;
  logic        expand_q;
  logic [15:0] len_q, len_d;
  logic [1:0]  skip_q, skip_d;
  logic        term_q, term_d;

  logic        accept;
  logic [7:0]  b;
  logic [16:0] cap_x, len_p1, len_p2, len_p3;
  logic        full_now, room_two;
  logic        is_lead, is_legal;
  logic [1:0]  lead_skip;
  cmd_t        cmd;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.payload.in_byte;

  assign cap_x    = {1'b0, cap_q};
  assign len_p1   = {1'b0, len_q} + 17'd1;
  assign len_p2   = {1'b0, len_q} + 17'd2;
  assign len_p3   = {1'b0, len_q} + 17'd3;
  assign full_now = len_p1 >= cap_x;
  assign room_two = len_p2 < cap_x;

  always_comb begin
    is_lead   = 1'b1;
    lead_skip = 2'd1;
    if (b[7:5] == 3'b110) begin
      lead_skip = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_skip = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      lead_skip = 2'd3;
    end else begin
      is_lead = 1'b0;
    end
    is_legal = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                         8'h2E, 8'h2D, 8'h5F, 8'h3A, 8'h20};
  end

  always_comb begin
    len_d  = len_q;
    skip_d = skip_q;
    term_d = term_q;
    cmd    = '0;
    if (b == CHAR_NUL) begin
      len_d  = '0;
      skip_d = '0;
      term_d = 1'b0;
      if (!term_q) begin
        cmd.cnt      = 2'd1;
        cmd.bytes[0] = CHAR_NUL;
      end
    end else if (term_q) begin
      cmd = '0;
    end else if (skip_q != 2'd0) begin
      skip_d = skip_q - 2'd1;
    end else if (full_now) begin
      term_d       = 1'b1;
      cmd.cnt      = 2'd1;
      cmd.bytes[0] = CHAR_NUL;
    end else if (!is_lead && !is_legal && expand_q && room_two) begin
      len_d        = len_p2[15:0];
      cmd.bytes[0] = EXPAND_LEAD | {6'd0, b[7:6]};
      cmd.bytes[1] = CONT_MARK | (b & CONT_MASK);
      if (len_p3 >= cap_x) begin
        term_d       = 1'b1;
        cmd.cnt      = 2'd3;
        cmd.bytes[2] = CHAR_NUL;
      end else begin
        cmd.cnt = 2'd2;
      end
    end else begin
      len_d        = len_p1[15:0];
      cmd.bytes[0] = is_legal ? b : CHAR_UNDERSCORE;
      if (is_lead) begin
        skip_d = lead_skip;
      end
      if (len_p2 >= cap_x) begin
        term_d       = 1'b1;
        cmd.cnt      = 2'd2;
        cmd.bytes[1] = CHAR_NUL;
      end else begin
        cmd.cnt = 2'd1;
      end
    end
  end

  assign push_o = accept && (cmd.cnt != 2'd0);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAPACITY_RESET;
      expand_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OUT_CAPACITY:   cap_q    <= cfg_data_i[15:0];
        REG_EXPAND_ILLEGAL: expand_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      skip_q <= '0;
      term_q <= 1'b0;
    end else if (accept) begin
      len_q  <= len_d;
      skip_q <= skip_d;
      term_q <= term_d;
    end
  end

endmodule

@@ rtl/nss_queue.sv @@
// Short command queue between front end and back end.
// Depends on nss_pkg for the command type.
module nss_queue #(
  parameter int unsigned Depth = nss_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nss_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output nss_pkg::cmd_t head_o
);
  import nss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/nss_back.sv @@
// Back end: walks the bytes of each queued command into the output register.
// Depends on nss_pkg and nss_stream_if; pops commands from nss_queue.
module nss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  nss_pkg::cmd_t head_i,
  output logic          pop_o,
  nss_stream_if.source  out_o
);
  import nss_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  out_item_t  item_q, item_d;
  logic       load, is_last;
  logic [7:0] cur_byte;

  assign load    = !valid_q || out_o.ready;
  assign is_last = idx_q == (head_i.cnt - 2'd1);

  always_comb begin
    case (idx_q)
      2'd0:    cur_byte = head_i.bytes[0];
      2'd1:    cur_byte = head_i.bytes[1];
      2'd2:    cur_byte = head_i.bytes[2];
      default: cur_byte = CHAR_NUL;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    item_d  = item_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        item_d.out_byte    = cur_byte;
        item_d.last_of_run = is_last;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = item_q;

endmodule

@@ rtl/nss_checker.sv @@
// Port-level checks on the sanitizer output stream, bound to the top level.
// Depends on nothing but the top-level ports it is bound to.
module nss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       last_of_run_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(last_of_run_i))
    else $error("output payload changed while stalled");

  a_nul_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_byte_i == 8'h00) |-> last_of_run_i)
    else $error("terminator not marked last of run");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=> out_valid_i)
    else $error("gap inside the output of one input byte");

endmodule

bind name_string_sanitizer nss_checker u_nss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.payload.out_byte),
  .last_of_run_i (out_o.payload.last_of_run)
);
